[hdl/markup_block_tokenizer_core_macros.svh]
// Assertion helpers shared by the tokenizer RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef MARKUP_BLOCK_TOKENIZER_CORE_MACROS_SVH
`define MARKUP_BLOCK_TOKENIZER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mbt_pkg.sv]
`default_nettype none

package mbt_pkg;

  // Longest name that can be compared, and the width of the name index.
  localparam int unsigned MaxName  = 8;
  localparam int unsigned NameIdxW = 4;
  localparam int unsigned NameSelW = 3;

  // Entries in the queue between the front and back parts.
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CharEscape    = 8'h5C;
  localparam logic [7:0] CharOptOpen   = 8'h5B;
  localparam logic [7:0] CharOptClose  = 8'h5D;
  localparam logic [7:0] CharContOpen  = 8'h7B;
  localparam logic [7:0] CharContClose = 8'h7D;

  typedef enum logic [2:0] {
    ModeText,
    ModeName,
    ModeOpt,
    ModeAfterOpt,
    ModeCont
  } mode_e;

  typedef enum logic [3:0] {
    ClassText,
    ClassEscape,
    ClassName,
    ClassOptOpen,
    ClassOptBody,
    ClassOptClose,
    ClassContOpen,
    ClassContBody,
    ClassContClose
  } byte_class_e;

  typedef enum logic [2:0] {
    ErrNone,
    ErrOptOpen,
    ErrContOpen,
    ErrNameAtEnd,
    ErrDepth
  } error_e;

  typedef enum logic [1:0] {
    CfgMatchName,
    CfgMatchLength,
    CfgMatchEnable
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [3:0] byte_class;
    logic [3:0] nest_depth;
    logic       name_done;
    logic       name_hit;
    logic [2:0] error_code;
    logic       final_res;
  } out_word_t;

  // Byte kinds found by the front part.
  typedef struct packed {
    logic is_escape;
    logic is_opt_open;
    logic is_opt_close;
    logic is_cont_open;
    logic is_cont_close;
    logic is_name_char;
  } byte_kind_t;

  typedef struct packed {
    byte_kind_t kind;
    logic [7:0] data_byte;
    logic       end_of_text;
  } cls_word_t;

  typedef struct packed {
    logic [63:0]         match_name;
    logic [NameIdxW-1:0] match_length;
    logic                match_enable;
  } cfg_t;

endpackage

`default_nettype wire

[hdl/mbt_front.sv]
`default_nettype none

module mbt_front
  import mbt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           push_valid_o,
  output cls_word_t      push_word_o,
  input  wire logic      queue_full_i
);

  logic      valid_q, valid_d;
  cls_word_t word_q, word_d;
  logic      accept;
  logic      push;

  assign in_stall_o = valid_q && queue_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = valid_q && !queue_full_i;

  // The byte kinds are stateless, so they are worked out before the register.
  always_comb begin
    word_d                    = word_q;
    word_d.data_byte          = in_word_i.data_byte;
    word_d.end_of_text        = in_word_i.end_of_text;
    word_d.kind.is_escape     = (in_word_i.data_byte == CharEscape);
    word_d.kind.is_opt_open   = (in_word_i.data_byte == CharOptOpen);
    word_d.kind.is_opt_close  = (in_word_i.data_byte == CharOptClose);
    word_d.kind.is_cont_open  = (in_word_i.data_byte == CharContOpen);
    word_d.kind.is_cont_close = (in_word_i.data_byte == CharContClose);
    word_d.kind.is_name_char  = in_word_i.data_byte inside
                                {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= word_d;
    end
  end

  assign push_valid_o = push;
  assign push_word_o  = word_q;

endmodule

`default_nettype wire

[hdl/mbt_queue.sv]
`default_nettype none

module mbt_queue
  import mbt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire cls_word_t push_word_i,
  output logic           full_o,
  output logic           pop_valid_o,
  input  wire logic      pop_i,
  output cls_word_t      pop_word_o
);

  localparam int unsigned PtrW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CountW = $clog2(QueueDepth + 1);

  cls_word_t         mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;

  assign full_o      = (count_q == CountW'(QueueDepth));
  assign pop_valid_o = (count_q != '0);
  assign pop_word_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

`default_nettype wire

[hdl/mbt_back.sv]
`default_nettype none

`include "markup_block_tokenizer_core_macros.svh"

module mbt_back
  import mbt_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = 15
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      pop_valid_i,
  input  wire cls_word_t pop_word_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  localparam int unsigned DepthW = $clog2(MAX_DEPTH + 1);

  mode_e               mode_q, mode_d, mode_nxt;
  logic [DepthW-1:0]   depth_q, depth_d, depth_nxt;
  logic [NameIdxW-1:0] idx_q, idx_d, idx_nxt;
  logic                mism_q, mism_d, mism_nxt;
  error_e              err_q, err_d, err_nxt;

  logic        out_valid_q;
  out_word_t   out_q;
  out_word_t   res;

  byte_kind_t  kind;
  logic        eot;
  logic        close_last;
  logic        at_limit;
  logic        overflow;
  logic        name_at_end;
  logic        name_done;
  logic        name_hit;
  byte_class_e cls;
  logic [7:0]  want;
  logic [31:0] depth_ext;

  assign kind       = pop_word_i.kind;
  assign eot        = pop_word_i.end_of_text;
  assign close_last = (depth_q <= DepthW'(1));
  assign at_limit   = (depth_q >= DepthW'(MAX_DEPTH));
  assign want       = cfg_i.match_name[8 * idx_q[NameSelW-1:0] +: 8];

  assign pop_o = pop_valid_i && (!out_valid_q || !out_stall_i);

  // Next parse mode.
  always_comb begin
    mode_nxt = mode_q;
    case (mode_q)
      ModeName: begin
        if (kind.is_name_char) begin
          mode_nxt = ModeName;
        end else if (kind.is_opt_open) begin
          mode_nxt = ModeOpt;
        end else if (kind.is_cont_open) begin
          mode_nxt = ModeCont;
        end else if (kind.is_escape) begin
          mode_nxt = ModeName;
        end else begin
          mode_nxt = ModeText;
        end
      end
      ModeOpt: begin
        if (kind.is_opt_close && close_last) begin
          mode_nxt = ModeAfterOpt;
        end
      end
      ModeAfterOpt: begin
        if (kind.is_cont_open) begin
          mode_nxt = ModeCont;
        end else if (kind.is_escape) begin
          mode_nxt = ModeName;
        end else begin
          mode_nxt = ModeText;
        end
      end
      ModeCont: begin
        if (kind.is_cont_close && close_last) begin
          mode_nxt = ModeText;
        end
      end
      default: begin
        mode_nxt = kind.is_escape ? ModeName : ModeText;
      end
    endcase
    mode_d = eot ? ModeText : mode_nxt;
  end

  // Class, depth, name tracking and errors for the byte at the queue head.
  always_comb begin
    cls         = ClassText;
    depth_nxt   = depth_q;
    idx_nxt     = idx_q;
    mism_nxt    = mism_q;
    overflow    = 1'b0;
    name_at_end = 1'b0;
    name_done   = 1'b0;
    name_hit    = 1'b0;
    case (mode_q)
      ModeName: begin
        if (kind.is_name_char) begin
          if (idx_q < NameIdxW'(MaxName) && idx_q < cfg_i.match_length) begin
            if (want != pop_word_i.data_byte) begin
              mism_nxt = 1'b1;
            end
            idx_nxt = idx_q + 1'b1;
          end else begin
            mism_nxt = 1'b1;
          end
          cls         = ClassName;
          name_at_end = eot;
        end else begin
          name_done = 1'b1;
          name_hit  = !cfg_i.match_enable ||
                      (!mism_q && idx_q == cfg_i.match_length &&
                       cfg_i.match_length <= NameIdxW'(MaxName));
          if (kind.is_opt_open) begin
            depth_nxt = DepthW'(1);
            cls       = ClassOptOpen;
          end else if (kind.is_cont_open) begin
            depth_nxt = DepthW'(1);
            cls       = ClassContOpen;
          end else if (kind.is_escape) begin
            idx_nxt  = '0;
            mism_nxt = 1'b0;
            cls      = ClassEscape;
          end
        end
      end
      ModeOpt: begin
        cls = ClassOptBody;
        if (kind.is_opt_open) begin
          if (at_limit) begin
            overflow = 1'b1;
          end else begin
            depth_nxt = depth_q + 1'b1;
          end
        end else if (kind.is_opt_close) begin
          depth_nxt = close_last ? '0 : depth_q - 1'b1;
          if (close_last) begin
            cls = ClassOptClose;
          end
        end
      end
      ModeAfterOpt: begin
        if (kind.is_cont_open) begin
          depth_nxt = DepthW'(1);
          cls       = ClassContOpen;
        end else if (kind.is_escape) begin
          idx_nxt  = '0;
          mism_nxt = 1'b0;
          cls      = ClassEscape;
        end
      end
      ModeCont: begin
        cls = ClassContBody;
        if (kind.is_cont_open) begin
          if (at_limit) begin
            overflow = 1'b1;
          end else begin
            depth_nxt = depth_q + 1'b1;
          end
        end else if (kind.is_cont_close) begin
          depth_nxt = close_last ? '0 : depth_q - 1'b1;
          if (close_last) begin
            cls = ClassContClose;
          end
        end
      end
      default: begin
        if (kind.is_escape) begin
          idx_nxt  = '0;
          mism_nxt = 1'b0;
          cls      = ClassEscape;
        end
      end
    endcase

    if (mode_nxt != ModeOpt && mode_nxt != ModeCont) begin
      depth_nxt = '0;
    end

    // The first error is kept; overflow on this byte wins over end errors.
    err_nxt = err_q;
    if (overflow && err_nxt == ErrNone) begin
      err_nxt = ErrDepth;
    end
    if (eot && err_nxt == ErrNone) begin
      if (mode_nxt == ModeOpt) begin
        err_nxt = ErrOptOpen;
      end else if (mode_nxt == ModeCont) begin
        err_nxt = ErrContOpen;
      end else if (name_at_end) begin
        err_nxt = ErrNameAtEnd;
      end
    end

    depth_ext = 32'(depth_nxt);

    res.byte_class = cls;
    res.nest_depth = depth_ext[3:0];
    res.name_done  = name_done;
    res.name_hit   = name_hit;
    res.error_code = err_nxt;
    res.final_res  = eot;

    depth_d = eot ? '0 : depth_nxt;
    idx_d   = eot ? '0 : idx_nxt;
    mism_d  = eot ? 1'b0 : mism_nxt;
    err_d   = eot ? ErrNone : err_nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeText;
      depth_q     <= '0;
      idx_q       <= '0;
      mism_q      <= 1'b0;
      err_q       <= ErrNone;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q      <= mode_d;
        depth_q     <= depth_d;
        idx_q       <= idx_d;
        mism_q      <= mism_d;
        err_q       <= err_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `MBT_ASSERT_NOW(a_hit_needs_done, out_valid_q && out_q.name_hit, out_q.name_done,
    "name_hit set without name_done")
  `MBT_ASSERT_NEXT(a_final_clears, pop_o && eot,
    mode_q == ModeText && depth_q == '0 && err_q == ErrNone,
    "state not cleared after final word")
  `MBT_ASSERT_NEXT(a_error_sticky, pop_o && !eot && err_q != ErrNone,
    err_q == $past(err_q), "sticky error changed before final word")
  `MBT_ASSERT_NOW(a_depth_in_body, depth_q != '0,
    mode_q == ModeOpt || mode_q == ModeCont, "depth nonzero outside options or contents")

endmodule

`default_nettype wire

[hdl/markup_block_tokenizer_core.sv]
// Markup block tokenizer: tags every byte of a \name[options]{contents} stream.
// Input channel: in_valid_i / in_stall_o with in_word_i carrying one byte and
// its end_of_text flag; a word is taken when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i with out_word_o carrying the byte
// class, nesting depth, name_done/name_hit and the sticky error code.
// Exactly one output word leaves for each input word, in order.
// A word taken on the input passes the front register, the queue and the output
// register of the parse engine before it shows on out_valid_o. Throughput is one
// word per cycle while the receiver does not stall; the back engine updates the
// parse state as each word leaves the queue. The configuration port writes
// match_name, match_length and match_enable by index with cfg_we_i; the user must
// write it only while no word is in flight, and the block does not enforce this.
// Reset clears the parse state, all valid flags and the configuration.
// When the receiver stalls, the output word holds and the queue fills; the
// input side stalls once the front register and both queue entries hold words,
// so at most four words wait in the block and none is lost or repeated.
// After a word with end_of_text set, the parse state returns to its reset value.
`default_nettype none

module markup_block_tokenizer_core
  import mbt_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = 15
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_word_t    in_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_word_t        out_word_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  // Configuration registers, written by index and read by the back engine.
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgMatchName:   cfg_d.match_name   = cfg_data_i;
        CfgMatchLength: cfg_d.match_length = cfg_data_i[NameIdxW-1:0];
        CfgMatchEnable: cfg_d.match_enable = cfg_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front part: registers each byte together with its byte kind.
  logic      push_valid;
  cls_word_t push_word;
  logic      queue_full;

  mbt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .push_valid_o (push_valid),
    .push_word_o  (push_word),
    .queue_full_i (queue_full)
  );

  // The queue decouples the front from the back, so each side stalls alone.
  logic      pop_valid;
  logic      pop;
  cls_word_t pop_word;

  mbt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_word_i (push_word),
    .full_o      (queue_full),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_word_o  (pop_word)
  );

  // Back part: the parse engine and the output register.
  mbt_back #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_word_i  (pop_word),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

[dv/markup_block_tokenizer_core_test.sv]
`default_nettype none

module markup_block_tokenizer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbt_pkg::*;

  // Depth limit of the instance, kept equal to the default of the block.
  localparam int unsigned DepthLimit = 15;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_word_t    in_word_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_word_t   out_word_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  markup_block_tokenizer_core #(
    .MAX_DEPTH(DepthLimit)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // The tagger state as this bench sees it, and its copy of the registers.
  mode_e       tk_mode;
  logic [3:0]  tk_depth;
  logic [3:0]  tk_nidx;
  logic        tk_miss;
  error_e      tk_err;
  logic [63:0] cfg_name;
  logic [3:0]  cfg_len;
  logic        cfg_en;

  // Tags predicted for accepted words, oldest first.
  out_word_t   pending_tags[$];
  int unsigned mismatch_count;
  int unsigned sent_count;
  int unsigned result_count;
  int unsigned quiet_left;

  // A row of the directed script. Where known is set, the tag is typed in
  // and pushed as it stands; otherwise the predictor supplies it.
  typedef struct {
    in_word_t  w;
    bit        known;
    out_word_t tag;
  } script_row_t;

  // The directed script runs with the registers at their reset values, so
  // the name compare is off and every finished name is a hit.
  script_row_t directed_script [26] = '{
    '{'{"a", 1'b0}, 1'b1, '{ClassText, 4'd0, 1'b0, 1'b0, ErrNone, 1'b0}},
    '{'{CharEscape, 1'b0}, 1'b1, '{ClassEscape, 4'd0, 1'b0, 1'b0, ErrNone, 1'b0}},
    '{'{"x", 1'b0}, 1'b1, '{ClassName, 4'd0, 1'b0, 1'b0, ErrNone, 1'b0}},
    '{'{CharOptOpen, 1'b0}, 1'b1, '{ClassOptOpen, 4'd1, 1'b1, 1'b1, ErrNone, 1'b0}},
    '{'{CharOptOpen, 1'b0}, 1'b0, '0},
    '{'{8'hFF, 1'b0}, 1'b0, '0},
    '{'{CharOptClose, 1'b0}, 1'b0, '0},
    '{'{CharOptClose, 1'b0}, 1'b1, '{ClassOptClose, 4'd0, 1'b0, 1'b0, ErrNone, 1'b0}},
    '{'{CharContOpen, 1'b0}, 1'b1, '{ClassContOpen, 4'd1, 1'b0, 1'b0, ErrNone, 1'b0}},
    '{'{8'h80, 1'b0}, 1'b0, '0},
    '{'{CharContClose, 1'b0}, 1'b1, '{ClassContClose, 4'd0, 1'b0, 1'b0, ErrNone, 1'b0}},
    // An empty name ended by a zero byte.
    '{'{CharEscape, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b1, '{ClassText, 4'd0, 1'b1, 1'b1, ErrNone, 1'b0}},
    // A name byte as the final byte of the text.
    '{'{CharEscape, 1'b0}, 1'b0, '0},
    '{'{"Z", 1'b1}, 1'b1, '{ClassName, 4'd0, 1'b0, 1'b0, ErrNameAtEnd, 1'b1}},
    // A backslash as the final byte raises nothing.
    '{'{CharEscape, 1'b1}, 1'b1, '{ClassEscape, 4'd0, 1'b0, 1'b0, ErrNone, 1'b1}},
    // Options still open at the end of the text.
    '{'{CharEscape, 1'b0}, 1'b0, '0},
    '{'{CharOptOpen, 1'b0}, 1'b0, '0},
    '{'{CharContOpen, 1'b1}, 1'b1, '{ClassOptBody, 4'd1, 1'b0, 1'b0, ErrOptOpen, 1'b1}},
    // Contents still open at the end of the text.
    '{'{CharEscape, 1'b0}, 1'b0, '0},
    '{'{"9", 1'b0}, 1'b0, '0},
    '{'{CharContOpen, 1'b0}, 1'b0, '0},
    '{'{CharContOpen, 1'b1}, 1'b1, '{ClassContBody, 4'd2, 1'b0, 1'b0, ErrContOpen, 1'b1}},
    // A backslash right after a backslash ends the empty name and opens
    // another one; a closing brace then ends that one as text.
    '{'{CharEscape, 1'b0}, 1'b0, '0},
    '{'{CharEscape, 1'b0}, 1'b0, '0},
    '{'{CharContClose, 1'b1}, 1'b0, '0}
  };

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic bit is_name_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // Only the first error of a text is kept.
  function automatic void raise_error(error_e e);
    if (tk_err == ErrNone) tk_err = e;
  endfunction

  // A byte seen as plain text; a backslash starts a new name.
  function automatic byte_class_e plain_byte(logic [7:0] c);
    if (c == CharEscape) begin
      tk_mode = ModeName;
      tk_nidx = '0;
      tk_miss = 1'b0;
      return ClassEscape;
    end
    tk_mode = ModeText;
    return ClassText;
  endfunction

  // A byte inside options or contents. Opening past the limit saturates
  // and flags the overflow; the closing byte that reaches depth zero gets
  // the close class and leaves the body.
  function automatic byte_class_e nest_byte(logic [7:0] c, logic [7:0] open, logic [7:0] close,
                                            byte_class_e body, mode_e after);
    if (c == open) begin
      if (tk_depth < DepthLimit) tk_depth = tk_depth + 4'd1;
      else raise_error(ErrDepth);
      return body;
    end
    if (c == close) begin
      if (tk_depth > 0) tk_depth = tk_depth - 4'd1;
      if (tk_depth == 0) begin
        tk_mode = after;
        return byte_class_e'(body + 1);
      end
    end
    return body;
  endfunction

  function automatic void clear_tagger();
    tk_mode  = ModeText;
    tk_depth = '0;
    tk_nidx  = '0;
    tk_miss  = 1'b0;
    tk_err   = ErrNone;
  endfunction

  // Works out the tag of one byte and advances the tagger state.
  function automatic out_word_t tag_byte(in_word_t w);
    byte_class_e cls;
    logic        done;
    logic        hit;
    logic        at_end;
    out_word_t   t;
    cls    = ClassText;
    done   = 1'b0;
    hit    = 1'b0;
    at_end = 1'b0;
    case (tk_mode)
      ModeName: begin
        if (is_name_char(w.data_byte)) begin
          // Characters past the configured length, or past the longest
          // comparable name, only spoil the match.
          if (tk_nidx < MaxName && tk_nidx < cfg_len) begin
            if (cfg_name[8*tk_nidx +: 8] != w.data_byte) tk_miss = 1'b1;
            tk_nidx = tk_nidx + 4'd1;
          end else begin
            tk_miss = 1'b1;
          end
          cls    = ClassName;
          at_end = w.end_of_text;
        end else begin
          done = 1'b1;
          hit  = !cfg_en || (!tk_miss && tk_nidx == cfg_len && cfg_len <= MaxName);
          if (w.data_byte == CharOptOpen) begin
            tk_mode  = ModeOpt;
            tk_depth = 4'd1;
            cls      = ClassOptOpen;
          end else if (w.data_byte == CharContOpen) begin
            tk_mode  = ModeCont;
            tk_depth = 4'd1;
            cls      = ClassContOpen;
          end else begin
            cls = plain_byte(w.data_byte);
          end
        end
      end
      ModeOpt: begin
        cls = nest_byte(w.data_byte, CharOptOpen, CharOptClose, ClassOptBody, ModeAfterOpt);
      end
      ModeAfterOpt: begin
        if (w.data_byte == CharContOpen) begin
          tk_mode  = ModeCont;
          tk_depth = 4'd1;
          cls      = ClassContOpen;
        end else begin
          cls = plain_byte(w.data_byte);
        end
      end
      ModeCont: begin
        cls = nest_byte(w.data_byte, CharContOpen, CharContClose, ClassContBody, ModeText);
      end
      default: begin
        cls = plain_byte(w.data_byte);
      end
    endcase

    if (tk_mode != ModeOpt && tk_mode != ModeCont) tk_depth = '0;

    if (w.end_of_text) begin
      if (tk_mode == ModeOpt) raise_error(ErrOptOpen);
      else if (tk_mode == ModeCont) raise_error(ErrContOpen);
      else if (at_end) raise_error(ErrNameAtEnd);
    end

    t.byte_class  = cls;
    t.nest_depth  = tk_depth;
    t.name_done   = done;
    t.name_hit    = hit;
    t.error_code  = tk_err;
    t.final_res   = w.end_of_text;

    // The state starts over with the next text; the registers stay.
    if (w.end_of_text) clear_tagger();
    return t;
  endfunction

  // ---------------------------------------------------------------------
  // Clock, reset and the checker
  // ---------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_fault(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Each word that leaves the block is held against the oldest tag waiting.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_tags.size() == 0) begin
        report_fault($sformatf("output word %h with no word pending", out_word_o));
      end else begin
        want = pending_tags.pop_front();
        if (out_word_o.byte_class !== want.byte_class)
          report_fault($sformatf("word %0d byte_class %0d, expected %0d", result_count,
                                 out_word_o.byte_class, want.byte_class));
        if (out_word_o.nest_depth !== want.nest_depth)
          report_fault($sformatf("word %0d nest_depth %0d, expected %0d", result_count,
                                 out_word_o.nest_depth, want.nest_depth));
        if (out_word_o.name_done !== want.name_done)
          report_fault($sformatf("word %0d name_done %b, expected %b", result_count,
                                 out_word_o.name_done, want.name_done));
        if (out_word_o.name_hit !== want.name_hit)
          report_fault($sformatf("word %0d name_hit %b, expected %b", result_count,
                                 out_word_o.name_hit, want.name_hit));
        if (out_word_o.error_code !== want.error_code)
          report_fault($sformatf("word %0d error_code %0d, expected %0d", result_count,
                                 out_word_o.error_code, want.error_code));
        if (out_word_o.final_res !== want.final_res)
          report_fault($sformatf("word %0d final_res %b, expected %b", result_count,
                                 out_word_o.final_res, want.final_res));
        result_count++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Random pacing
  // ---------------------------------------------------------------------

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // The receiver alternates between free runs and stalls. Some free runs
  // are long so that the block also sees stretches at full rate.
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      int unsigned free_run;
      int unsigned hold;
      free_run = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 6);
      out_stall_i = 1'b0;
      repeat (free_run) @(negedge clk_i);
      hold = pick_gap();
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Offers one word, waits until the block takes it, and records its tag.
  // The valid stays high after acceptance so that back to back words are
  // possible; the next call either replaces the word or lowers valid.
  task automatic send_byte(logic [7:0] c, logic eot, bit known = 1'b0, out_word_t tag = '0);
    in_word_t    w;
    out_word_t   t;
    int unsigned gap;
    w.data_byte   = c;
    w.end_of_text = eot;
    gap = 0;
    if (quiet_left > 0) begin
      quiet_left--;
    end else begin
      if ($urandom_range(0, 39) == 0) quiet_left = $urandom_range(60, 200);
      gap = pick_gap();
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_word_i  = w;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    t = tag_byte(w);
    pending_tags.push_back(known ? tag : t);
    sent_count++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [63:0] value);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    case (idx)
      CfgMatchName:   cfg_name = value;
      CfgMatchLength: cfg_len  = value[3:0];
      CfgMatchEnable: cfg_en   = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Lowers valid and waits until every word has come back and the pipeline has
  // settled, so that the registers can change.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_tags.size() != 0) @(posedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_name_char();
    int unsigned r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    return 8'("a" + r - 36);
  endfunction

  // Body bytes: mostly printable, some of every value.
  function automatic logic [7:0] pick_filler();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(32, 126));
    return 8'($urandom_range(0, 255));
  endfunction

  // A block name: half the time the configured name, a quarter of the time
  // the configured name with one character changed, the rest of random
  // length. Rarely the text ends on the last name character.
  task automatic send_name(output bit ended);
    int unsigned k;
    int          len;
    int          flip;
    logic [7:0]  ch;
    ended = 1'b0;
    k     = $urandom_range(0, 99);
    len   = (cfg_len > MaxName) ? MaxName : cfg_len;
    if (k >= 75) len = $urandom_range(0, 10);
    flip = (k >= 50 && k < 75 && len > 0) ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      ch = (k < 75 && i < MaxName) ? cfg_name[8*i +: 8] : rand_name_char();
      if (!is_name_char(ch) || i == flip) ch = rand_name_char();
      ended = (i == len - 1) && ($urandom_range(0, 99) < 4);
      send_byte(ch, ended);
      if (ended) return;
    end
  endtask

  // The body of options or contents after its opening byte. Bodies nest a
  // few levels; now and then one runs far past the depth limit, and now
  // and then the text ends with the body still open.
  task automatic send_nest(logic [7:0] open, logic [7:0] close);
    int          depth;
    int unsigned count;
    int unsigned r;
    bit          deep;
    depth = 1;
    deep  = ($urandom_range(0, 11) == 0);
    count = deep ? DepthLimit + 2 : $urandom_range(0, 8);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (deep || r < 25) begin
        send_byte(open, 1'b0);
        depth++;
      end else if (r < 45 && depth > 1) begin
        send_byte(close, 1'b0);
        depth--;
      end else begin
        send_byte(pick_filler(), 1'b0);
      end
    end
    if ($urandom_range(0, 99) < 4) begin
      send_byte(pick_filler(), 1'b1);
      return;
    end
    while (depth > 0) begin
      send_byte(close, 1'b0);
      depth--;
    end
  endtask

  // One setting of the registers and a stretch of random markup under it.
  // Most of the traffic is well-formed blocks with random content; the
  // rest is stray bytes and texts cut short.
  task automatic run_phase(logic [63:0] name, logic [3:0] len, logic en, int unsigned budget);
    int unsigned stop_at;
    int unsigned r;
    bit          ended;
    drain();
    write_reg(CfgMatchName, name);
    write_reg(CfgMatchLength, {60'd0, len});
    write_reg(CfgMatchEnable, {63'd0, en});
    stop_at = sent_count + budget;
    while (sent_count < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) == 0);
      end else begin
        send_byte(CharEscape, 1'b0);
        send_name(ended);
        if (!ended) begin
          r = $urandom_range(0, 99);
          if (r < 45) begin
            send_byte(CharOptOpen, 1'b0);
            send_nest(CharOptOpen, CharOptClose);
            if ($urandom_range(0, 99) < 65) begin
              send_byte(CharContOpen, 1'b0);
              send_nest(CharContOpen, CharContClose);
            end
          end else if (r < 80) begin
            send_byte(CharContOpen, 1'b0);
            send_nest(CharContOpen, CharContClose);
          end else begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
          end
          if ($urandom_range(0, 99) < 8) send_byte(pick_filler(), 1'b1);
        end
      end
    end
    // Close the text so that no half-parsed name sees the next setting.
    send_byte(pick_filler(), 1'b1);
  endtask

  initial begin
    logic [63:0] word_name;
    in_valid_i     = 1'b0;
    in_word_i      = '0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CfgMatchName;
    cfg_data_i     = '0;
    cfg_name       = '0;
    cfg_len        = '0;
    cfg_en         = 1'b0;
    mismatch_count = 0;
    sent_count     = 0;
    result_count   = 0;
    quiet_left     = 0;
    clear_tagger();

    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_script[i])
      send_byte(directed_script[i].w.data_byte, directed_script[i].w.end_of_text,
                directed_script[i].known, directed_script[i].tag);

    // A short name.
    run_phase(64'h0000_0000_0063_6573, 4'd3, 1'b1, 200);
    // The longest name that can be compared.
    for (int i = 0; i < MaxName; i++) word_name[8*i +: 8] = rand_name_char();
    run_phase(word_name, 4'd8, 1'b1, 200);
    // Only an empty name matches.
    run_phase(64'd0, 4'd0, 1'b1, 200);
    // A length past the longest name: nothing can match.
    run_phase({64{1'b1}}, 4'd15, 1'b1, 200);
    // A name of random length.
    for (int i = 0; i < MaxName; i++) word_name[8*i +: 8] = rand_name_char();
    run_phase(word_name, 4'($urandom_range(1, 7)), 1'b1, 200);
    // Compare switched off again, with random register contents.
    run_phase({$urandom, $urandom}, 4'($urandom_range(0, 8)), 1'b0, 200);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_tags.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
